[rtl/core/ptis_pkg.sv]
// Package for the polyline tangent index stream block.
// Shared constants and the sequencer state type; no dependencies.
`timescale 1ns / 1ps
package ptis_pkg;
  localparam int COORD_WIDTH_DEF = 24;
  localparam int DIRECTION_WIDTH_DEF = 16;
  localparam int INDEX_WIDTH_DEF = 32;
  localparam int BUNDLE_WIDTH = 16;
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_NORM  = 9'b000000010,
    ST_SQ    = 9'b000000100,
    ST_SQRT  = 9'b000001000,
    ST_DIV   = 9'b000010000,
    ST_EMIT1 = 9'b000100000,
    ST_EMIT2 = 9'b001000000,
    ST_EMIT3 = 9'b010000000,
    ST_WAIT  = 9'b100000000
  } state_t;
endpackage

[rtl/core/polyline_tangent_index_stream.sv]
// Top level of the polyline tangent index stream block.
// Depends on ptis_pkg for constants and the state type.
//
// Usage: points enter on the in_ stream (x, y, z in tdata, bundle in tuser,
// last point of a fiber on tlast). For each point after the first of a fiber
// a vertex transfer goes out on the out_ stream with its unit direction;
// the last point of a fiber also yields its own vertex and a restart marker
// (tuser bit 0 high, index all ones). out_tlast marks the last transfer
// caused by one input point.
// Flow: in_tready is high only when the block is idle. A point with a
// predecessor runs the shared datapath: accept, normalizing shift (one bit
// per cycle), squares, the bit-pair square root, the restoring divisions
// and loading the vertex. A zero-length segment skips from the normalizing
// shift straight to the vertex. A last point adds its own vertex, the marker
// and a wait state. A first point is only accepted; a one-point fiber yields
// its own vertex, the marker and the wait state. Each result sits in an
// output register until taken; a receiver stall only holds that register
// and the sequencer. Reset clears the fiber state, sets the last direction
// to full scale on all axes and empties the output.
`timescale 1ns / 1ps
module polyline_tangent_index_stream #(
  parameter int COORD_WIDTH = ptis_pkg::COORD_WIDTH_DEF,
  parameter int DIRECTION_WIDTH = ptis_pkg::DIRECTION_WIDTH_DEF,
  parameter int INDEX_WIDTH = ptis_pkg::INDEX_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // pos_x, pos_y, pos_z from bit 0 up
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic in_tlast,
  // bundle_id
  input  logic [ptis_pkg::BUNDLE_WIDTH-1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // element_index, normal_x, normal_y, normal_z, bundle_tag from bit 0 up
  output logic [((INDEX_WIDTH+3*DIRECTION_WIDTH+ptis_pkg::BUNDLE_WIDTH+7)/8)*8-1:0]
    out_tdata,
  output logic out_tlast,
  // entry_kind, degenerate
  output logic [1:0] out_tuser
);
  localparam int CW = COORD_WIDTH;
  localparam int DW = DIRECTION_WIDTH;
  localparam int IW = INDEX_WIDTH;
  localparam int BW = ptis_pkg::BUNDLE_WIDTH;
  localparam int MW = CW + 1;              // difference magnitude
  localparam int NW = (MW > 30) ? MW : 30; // normalized magnitude
  localparam int SW = 64;                  // sum of squares
  localparam int RW = 32;                  // root
  localparam int QB = DW;                  // quotient bits computed
  localparam int XW = 31 + DW;             // divide remainder width
  localparam int OW = $bits(out_tdata);
  localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};

  ptis_pkg::state_t st_r;

  logic signed [CW-1:0] prev_r [3];
  logic [DW-1:0] dir_r [3];
  logic degen_r, have_r;
  logic [IW-1:0] cnt_r;
  logic [BW-1:0] pbund_r, bund_r;
  logic last_r;

  logic [NW-1:0] mag_r [3];
  logic [2:0] neg_r;
  logic [1:0] ax_r;
  logic [SW-1:0] sum_r, rem_r, bit_r, root_r;
  logic [XW-1:0] drem_r;
  logic [QB-1:0] q_r;
  logic [5:0] it_r;

  logic o_valid_r, o_last_r;
  logic [OW-1:0] o_data_r;
  logic [1:0] o_user_r;

  logic signed [CW:0] diff [3];
  logic [MW-1:0] dmag [3];
  logic [NW-1:0] mx;
  logic [59:0] sq;
  logic [SW-1:0] trial;
  logic [XW-1:0] dsh;
  logic [XW-1:0] nden;
  logic out_free;
  logic o_load;

  assign out_free = !o_valid_r || out_tready;
  assign in_tready = (st_r == ptis_pkg::ST_IDLE);
  assign o_load = out_free && (st_r == ptis_pkg::ST_EMIT1 || st_r == ptis_pkg::ST_EMIT2 ||
                               st_r == ptis_pkg::ST_EMIT3);

  // per-axis difference from the stored point
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = $signed({in_tdata[a*CW+CW-1], in_tdata[a*CW +: CW]})
              - $signed({prev_r[a][CW-1], prev_r[a]});
      dmag[a] = diff[a][CW] ? MW'(-diff[a]) : MW'(diff[a]);
    end
    mx = mag_r[0] | mag_r[1] | mag_r[2];
    sq = mag_r[ax_r][29:0] * mag_r[ax_r][29:0];
    trial = root_r + bit_r;
    dsh = {drem_r[XW-2:0], 1'b0};
    nden = XW'(root_r);
  end

  // output valid: set on a load, cleared when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_load) begin
      o_valid_r <= 1'b1;
    end else if (out_tready) begin
      o_valid_r <= 1'b0;
    end
  end

  // sequencer and shared datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ptis_pkg::ST_IDLE;
      have_r <= 1'b0;
      degen_r <= 1'b0;
      cnt_r <= '0;
      pbund_r <= '0;
      for (int a = 0; a < 3; a++) begin
        prev_r[a] <= '0;
        dir_r[a] <= DMAX;
      end
    end else begin
      unique case (st_r)
        ptis_pkg::ST_IDLE: begin
          if (in_tvalid) begin
            last_r <= in_tlast;
            bund_r <= in_tuser;
            for (int a = 0; a < 3; a++) begin
              mag_r[a] <= NW'(dmag[a]);
              neg_r[a] <= diff[a][CW];
            end
            if (!in_tlast) begin
              for (int a = 0; a < 3; a++) prev_r[a] <= in_tdata[a*CW +: CW];
            end
            // predecessor tag moves on only after its vertex went out
            if (!in_tlast && !have_r) pbund_r <= in_tuser;
            have_r <= !in_tlast;
            if (have_r) st_r <= ptis_pkg::ST_NORM;
            else if (in_tlast) st_r <= ptis_pkg::ST_EMIT2;
          end
        end
        // joint shift into [2^29, 2^30) one bit per cycle
        ptis_pkg::ST_NORM: begin
          if (mx == '0) begin
            for (int a = 0; a < 3; a++) dir_r[a] <= '0;
            degen_r <= 1'b1;
            st_r <= ptis_pkg::ST_EMIT1;
          end else if (|(mx >> 30)) begin
            for (int a = 0; a < 3; a++) mag_r[a] <= mag_r[a] >> 1;
          end else if (!mx[29]) begin
            for (int a = 0; a < 3; a++) mag_r[a] <= mag_r[a] << 1;
          end else begin
            sum_r <= '0;
            ax_r <= '0;
            st_r <= ptis_pkg::ST_SQ;
          end
        end
        // one square per cycle
        ptis_pkg::ST_SQ: begin
          sum_r <= sum_r + SW'(sq);
          if (ax_r == 2'd2) begin
            st_r <= ptis_pkg::ST_SQRT;
            rem_r <= sum_r + SW'(sq);
            bit_r <= SW'(1) << 62;
            root_r <= '0;
          end
          ax_r <= ax_r + 2'd1;
        end
        // bit-pair square root, one pair per cycle
        ptis_pkg::ST_SQRT: begin
          if (rem_r >= trial) begin
            rem_r <= rem_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            st_r <= ptis_pkg::ST_DIV;
            ax_r <= '0;
            it_r <= '0;
          end
        end
        // restoring divide per axis; dividend mag<<(DW-1) + root/2
        ptis_pkg::ST_DIV: begin
          if (it_r == '0) begin
            drem_r <= '0;
            q_r <= '0;
            it_r <= 6'd1;
          end else begin
            logic [XW-1:0] num, cand;
            logic nb;
            logic [5:0] bidx;
            logic [QB:0] qsat;
            num = (XW'(mag_r[ax_r][29:0]) << (DW-1)) + XW'(root_r[RW-1:1]);
            bidx = 6'(XW) - it_r;
            nb = num[bidx];
            cand = dsh | XW'(nb);
            qsat = {1'b0, q_r[QB-2:0], (cand >= nden)};
            if (cand >= nden) begin
              drem_r <= cand - nden;
              q_r <= {q_r[QB-2:0], 1'b1};
            end else begin
              drem_r <= cand;
              q_r <= {q_r[QB-2:0], 1'b0};
            end
            if (it_r == 6'(XW)) begin
              it_r <= '0;
              if (|(q_r >> (DW-2)) || qsat > (QB+1)'(DMAX))
                dir_r[ax_r] <= neg_r[ax_r] ? -DMAX : DMAX;
              else
                dir_r[ax_r] <= neg_r[ax_r] ? -qsat[DW-1:0] : qsat[DW-1:0];
              if (ax_r == 2'd2) begin
                degen_r <= 1'b0;
                st_r <= ptis_pkg::ST_EMIT1;
              end
              ax_r <= ax_r + 2'd1;
            end else begin
              it_r <= it_r + 6'd1;
            end
          end
        end
        // vertex for the predecessor
        ptis_pkg::ST_EMIT1: if (out_free) begin
          o_data_r <= OW'({pbund_r, dir_r[2], dir_r[1], dir_r[0], cnt_r});
          o_user_r <= {degen_r, ptis_pkg::KIND_VERTEX};
          o_last_r <= !last_r;
          cnt_r <= cnt_r + IW'(1);
          if (!last_r) pbund_r <= bund_r;
          st_r <= last_r ? ptis_pkg::ST_EMIT2 : ptis_pkg::ST_IDLE;
        end
        // vertex for the last point
        ptis_pkg::ST_EMIT2: if (out_free) begin
          o_data_r <= OW'({bund_r, dir_r[2], dir_r[1], dir_r[0], cnt_r});
          o_user_r <= {degen_r, ptis_pkg::KIND_VERTEX};
          o_last_r <= 1'b0;
          cnt_r <= cnt_r + IW'(1);
          st_r <= ptis_pkg::ST_EMIT3;
        end
        // restart marker
        ptis_pkg::ST_EMIT3: if (out_free) begin
          o_data_r <= OW'({IW{1'b1}});
          o_user_r <= {1'b0, ptis_pkg::KIND_RESTART};
          o_last_r <= 1'b1;
          st_r <= ptis_pkg::ST_WAIT;
        end
        ptis_pkg::ST_WAIT: st_r <= ptis_pkg::ST_IDLE;
        default: st_r <= ptis_pkg::ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata = o_data_r;
  assign out_tlast = o_last_r;
  assign out_tuser = o_user_r;

  // a held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");
  // a marker always carries all-ones index and ends the run
  a_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && (out_tdata[IW-1:0] == {IW{1'b1}}))
    else $error("bad restart marker");
  // not ready while working
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ptis_pkg::ST_IDLE |-> !in_tready)
    else $error("ready while busy");
endmodule
